/* design/current_derated_pi_speed_loop_top_macros.svh */
// Assertion macros used by the checker of the current-derated speed loop.
`ifndef CURRENT_DERATED_PI_SPEED_LOOP_TOP_MACROS_SVH
`define CURRENT_DERATED_PI_SPEED_LOOP_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define CDPSL_CHECK_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cdpsl: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define CDPSL_CHECK_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cdpsl: next-cycle check failed");

`endif

/* design/cdpsl_pkg.sv */
// Package of the current-derated speed loop: widths, register codes, microcode.
`default_nettype none

package cdpsl_pkg;

	localparam int FRACTION_BITS = 24;
	localparam int DUTY_W        = 31;
	localparam int STATE_W       = 40;
	localparam int DIFF_W        = STATE_W + 1;
	localparam int ACC_W         = 52;
	localparam int FIELD_W       = 16;
	localparam int WHEEL_COUNT   = 2;
	localparam int WHEEL_W       = 1;

	localparam int PCT_W   = 7;
	localparam int LIMIT_W = 15;
	localparam int GAIN_W  = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Shared multiplier: MUL_A_W by GAIN_W bits, unsigned.
	localparam int MUL_A_W = 20;
	localparam int MUL_P_W = MUL_A_W + GAIN_W;

	// Divider: 32-bit dividend, DIV_BITS quotient bits per step.
	localparam int QUOT_W    = 32;
	localparam int DIV_BITS  = 4;
	localparam int DIV_ITER  = QUOT_W / DIV_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_ITER);

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_NEUTRAL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDUP_GAIN   = 3'd5;

	localparam logic [PCT_W-1:0]   RST_NEUTRAL = 7'd50;
	localparam logic [PCT_W-1:0]   RST_FLOOR   = 7'd0;
	localparam logic [PCT_W-1:0]   RST_CEILING = 7'd100;
	localparam logic [LIMIT_W-1:0] RST_LIMIT   = 15'd1000;
	localparam logic [GAIN_W-1:0]  RST_PGAIN   = 16'd839;
	localparam logic [GAIN_W-1:0]  RST_WGAIN   = 16'd39322;

	// Largest duty any setting of the 7-bit percent registers can produce.
	localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(7'h7F) << FRACTION_BITS;

	function automatic logic [DUTY_W-1:0] pct_scale(input logic [PCT_W-1:0] pct);
		return DUTY_W'(pct) << FRACTION_BITS;
	endfunction

	// Microcode fields.
	typedef enum logic [2:0] {MUL_NONE, MUL_ERR, MUL_PLO, MUL_PHI, MUL_WLO, MUL_WHI} mul_sel_t;
	typedef enum logic [2:0] {ACC_NONE, ACC_INIT, ACC_PLO, ACC_PHI, ACC_WLO, ACC_WHI} acc_op_t;
	typedef enum logic [1:0] {DIV_NONE, DIV_LOAD, DIV_STEP} div_op_t;
	typedef enum logic [1:0] {WIN_NONE, WIN_DIFF, WIN_MAG} win_op_t;
	typedef enum logic [1:0] {FIN_NONE, FIN_SAT, FIN_WRITE} fin_op_t;
	typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT_IN, JMP_LOOP, JMP_WAIT_OUT} jump_t;

	typedef logic [3:0] step_t;

	localparam step_t STEP_WAIT  = 4'd0;
	localparam step_t STEP_ERR   = 4'd1;
	localparam step_t STEP_DIVLD = 4'd2;
	localparam step_t STEP_DIV   = 4'd3;
	localparam step_t STEP_PLO   = 4'd4;
	localparam step_t STEP_PHI   = 4'd5;
	localparam step_t STEP_WLO   = 4'd6;
	localparam step_t STEP_WHI   = 4'd7;
	localparam step_t STEP_WACC  = 4'd8;
	localparam step_t STEP_SAT   = 4'd9;
	localparam step_t STEP_WRITE = 4'd10;

	typedef struct packed {
		mul_sel_t mul;
		acc_op_t  acc;
		div_op_t  div;
		win_op_t  win;
		fin_op_t  fin;
		jump_t    jump;
		step_t    target;
	} ucode_t;

	// Control store: one word per step.
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		w = '{mul: MUL_NONE, acc: ACC_NONE, div: DIV_NONE, win: WIN_NONE,
			fin: FIN_NONE, jump: JMP_NEXT, target: STEP_WAIT};
		unique case (s)
			STEP_WAIT: begin
				w.jump = JMP_WAIT_IN;
			end
			STEP_ERR: begin
				w.mul = MUL_ERR;
				w.acc = ACC_INIT;
				w.win = WIN_DIFF;
			end
			STEP_DIVLD: begin
				w.div = DIV_LOAD;
				w.win = WIN_MAG;
			end
			STEP_DIV: begin
				w.div    = DIV_STEP;
				w.jump   = JMP_LOOP;
				w.target = STEP_DIV;
			end
			STEP_PLO: begin
				w.mul = MUL_PLO;
			end
			STEP_PHI: begin
				w.mul = MUL_PHI;
				w.acc = ACC_PLO;
			end
			STEP_WLO: begin
				w.mul = MUL_WLO;
				w.acc = ACC_PHI;
			end
			STEP_WHI: begin
				w.mul = MUL_WHI;
				w.acc = ACC_WLO;
			end
			STEP_WACC: begin
				w.acc = ACC_WHI;
			end
			STEP_SAT: begin
				w.fin = FIN_SAT;
			end
			STEP_WRITE: begin
				w.fin    = FIN_WRITE;
				w.jump   = JMP_WAIT_OUT;
				w.target = STEP_WAIT;
			end
			default: begin
				w.jump   = JMP_WAIT_OUT;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* design/cdpsl_if.sv */
// Channel interfaces of the current-derated speed loop: item, result, configuration.
`default_nettype none

interface cdpsl_in_if;
	import cdpsl_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [WHEEL_W-1:0]        wheel_select;
	logic signed [FIELD_W-1:0] target_speed;
	logic signed [FIELD_W-1:0] motor_current;
	logic signed [FIELD_W-1:0] measured_speed;

	modport source (output valid, wheel_select, target_speed, motor_current,
		measured_speed, input ready);
	modport sink (input valid, wheel_select, target_speed, motor_current,
		measured_speed, output ready);
endinterface

interface cdpsl_out_if;
	import cdpsl_pkg::*;
	logic              valid;
	logic              ready;
	logic [DUTY_W-1:0] applied_duty;
	logic [DUTY_W-1:0] next_duty;
	logic              over_current;

	modport source (output valid, applied_duty, next_duty, over_current, input ready);
	modport sink (input valid, applied_duty, next_duty, over_current, output ready);
endinterface

interface cdpsl_cfg_if;
	import cdpsl_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/current_derated_pi_speed_loop_top.sv */
// Two-wheel current-derated speed loop, top level.
`default_nettype none

// Speed regulator for two wheels. Each item beat names a wheel and carries the
// speed command, the motor current and the measured speed; the block answers
// with one result beat holding the duty stored from that wheel's last update
// (applied_duty), the newly computed duty (next_duty) and the over-current flag.
// Duties are unsigned fixed point in units of 2^-24 percent. The work is run by
// a small microprogram over one shared 20x16 multiplier, a 52-bit accumulator
// and a radix-16 restoring divider. Each item runs through its steps in turn:
// accept the beat, form the derating product and windup difference, run eight
// divider steps of four quotient bits each (the longest part of the item), then
// five multiply/accumulate steps, and at the end saturate the result and write
// back. The result sits in an output register; the next item is accepted while
// it waits, and the sequencer holds at its write step only if a second result
// is ready before the first has been taken. Configuration beats are taken in
// any cycle (cfg.ready is tied high) and must only come while the block is idle.
module current_derated_pi_speed_loop_top (
	input  logic            clk,
	input  logic            arst_n,
	cdpsl_in_if.sink        item,
	cdpsl_out_if.source     result,
	cdpsl_cfg_if.sink       cfg
);
	import cdpsl_pkg::*;

	// Configuration registers.
	logic [PCT_W-1:0]   neutral_q;
	logic [PCT_W-1:0]   floor_q;
	logic [PCT_W-1:0]   ceil_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [GAIN_W-1:0]  pgain_q;
	logic [GAIN_W-1:0]  wgain_q;

	// Per-wheel loop state.
	logic signed [STATE_W-1:0] lm_q  [WHEEL_COUNT];
	logic signed [STATE_W-1:0] unc_q [WHEEL_COUNT];
	logic [DUTY_W-1:0]         held_q[WHEEL_COUNT];

	// Captured item.
	logic [WHEEL_W-1:0]        wheel_q;
	logic signed [FIELD_W-1:0] cmd_q;
	logic signed [FIELD_W-1:0] cur_q;
	logic signed [FIELD_W-1:0] spd_q;

	// Sequencer.
	step_t  step_q;
	step_t  step_n;
	ucode_t cw;

	// Datapath registers.
	logic [MUL_P_W-1:0]       p_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic [STATE_W-1:0]       aw_mag_q;
	logic                     aw_neg_q;
	logic [LIMIT_W-1:0]       rem_q;
	logic [QUOT_W-1:0]        dq_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic signed [STATE_W-1:0] u_q;

	// Output register.
	logic              out_valid_q;
	logic [DUTY_W-1:0] applied_q;
	logic [DUTY_W-1:0] next_q;
	logic              over_q;

	// Scaled bounds.
	logic [DUTY_W-1:0] neutral_s;
	logic [DUTY_W-1:0] floor_s;
	logic [DUTY_W-1:0] ceil_s;

	assign neutral_s = pct_scale(neutral_q);
	assign floor_s   = pct_scale(floor_q);
	assign ceil_s    = pct_scale(ceil_q);

	// Handshakes.
	logic item_fire;
	logic out_free;
	logic do_write;

	assign cw        = ucode_rom(step_q);
	assign item.ready = (cw.jump == JMP_WAIT_IN);
	assign item_fire = item.valid && item.ready;
	assign out_free  = !out_valid_q || result.ready;
	assign do_write  = (cw.fin == FIN_WRITE) && out_free;
	assign cfg.ready = 1'b1;

	assign result.valid        = out_valid_q;
	assign result.applied_duty = applied_q;
	assign result.next_duty    = next_q;
	assign result.over_current = over_q;

	// Item decode: speed error, current magnitude, derating factor.
	logic signed [FIELD_W:0] err;
	logic [FIELD_W-1:0]      err_mag;
	logic [FIELD_W-1:0]      cur_mag;
	logic signed [FIELD_W:0] drate;
	logic [FIELD_W-1:0]      drate_mag;
	logic                    cmd_nz;
	logic                    over;
	logic                    sc_neg;
	logic                    lim_zero;

	assign err       = (FIELD_W+1)'(cmd_q) - (FIELD_W+1)'(spd_q);
	assign err_mag   = err[FIELD_W] ? FIELD_W'(-err) : err[FIELD_W-1:0];
	assign cur_mag   = cur_q[FIELD_W-1] ? FIELD_W'(-cur_q) : FIELD_W'(cur_q);
	assign drate     = $signed((FIELD_W+1)'(limit_q)) - $signed((FIELD_W+1)'(cur_mag));
	assign drate_mag = drate[FIELD_W] ? FIELD_W'(-drate) : drate[FIELD_W-1:0];
	assign cmd_nz    = (cmd_q != '0);
	assign over      = cmd_nz && (cur_mag > FIELD_W'(limit_q));
	// Sign of the scaled error; a zero product makes it irrelevant.
	assign sc_neg    = err[FIELD_W] ^ drate[FIELD_W];
	assign lim_zero  = (limit_q == '0);

	// Windup difference against the bound that the stored unclamped output crossed.
	logic signed [DIFF_W-1:0] prev_x;
	logic signed [DIFF_W-1:0] hi_x;
	logic signed [DIFF_W-1:0] lo_x;
	logic signed [DIFF_W-1:0] diff_n;

	assign prev_x = DIFF_W'(unc_q[wheel_q]);
	assign hi_x   = $signed(DIFF_W'(ceil_s));
	assign lo_x   = $signed(DIFF_W'(floor_s));

	always_comb begin
		priority if (prev_x > hi_x) begin
			diff_n = prev_x - hi_x;
		end else if (prev_x < lo_x) begin
			diff_n = prev_x - lo_x;
		end else begin
			diff_n = '0;
		end
	end

	// Quotient of the derated error; a zero limit forces it to zero.
	logic [QUOT_W-1:0] quot;
	assign quot = lim_zero ? '0 : dq_q;

	// Shared multiplier operand select.
	logic [MUL_A_W-1:0] mul_a;
	logic [GAIN_W-1:0]  mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cw.mul)
			MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			MUL_ERR: begin
				mul_a = MUL_A_W'(err_mag);
				mul_b = drate_mag;
			end
			MUL_PLO: begin
				mul_a = quot[MUL_A_W-1:0];
				mul_b = pgain_q;
			end
			MUL_PHI: begin
				mul_a = MUL_A_W'(quot[QUOT_W-1:MUL_A_W]);
				mul_b = pgain_q;
			end
			MUL_WLO: begin
				mul_a = aw_mag_q[MUL_A_W-1:0];
				mul_b = wgain_q;
			end
			MUL_WHI: begin
				mul_a = aw_mag_q[STATE_W-1:MUL_A_W];
				mul_b = wgain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Accumulator term: product placed at its weight, added or subtracted.
	logic [ACC_W-1:0] acc_term;
	logic             acc_sub;

	always_comb begin
		acc_term = '0;
		acc_sub  = 1'b0;
		unique case (cw.acc)
			ACC_NONE, ACC_INIT: begin
				acc_term = '0;
				acc_sub  = 1'b0;
			end
			ACC_PLO: begin
				acc_term = ACC_W'(p_q);
				acc_sub  = sc_neg;
			end
			ACC_PHI: begin
				acc_term = ACC_W'(p_q) << MUL_A_W;
				acc_sub  = sc_neg;
			end
			// Windup product is shifted down by the gain's fraction bits; the
			// low half drops its fraction, the high half lands above it.
			ACC_WLO: begin
				acc_term = ACC_W'(p_q >> GAIN_W);
				acc_sub  = !aw_neg_q;
			end
			ACC_WHI: begin
				acc_term = ACC_W'(p_q) << (MUL_A_W - GAIN_W);
				acc_sub  = !aw_neg_q;
			end
			default: begin
				acc_term = '0;
				acc_sub  = 1'b0;
			end
		endcase
	end

	// Four restoring divide steps per cycle.
	logic [LIMIT_W-1:0] div_rem_n;
	logic [QUOT_W-1:0]  div_quo_n;
	logic [LIMIT_W:0]   div_trial;

	always_comb begin
		div_rem_n = rem_q;
		div_quo_n = dq_q;
		div_trial = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			div_trial = {div_rem_n, div_quo_n[QUOT_W-1]};
			div_quo_n = {div_quo_n[QUOT_W-2:0], 1'b0};
			if (div_trial >= (LIMIT_W+1)'(limit_q)) begin
				div_trial    = div_trial - (LIMIT_W+1)'(limit_q);
				div_quo_n[0] = 1'b1;
			end
			div_rem_n = div_trial[LIMIT_W-1:0];
		end
	end

	logic cnt_last;
	assign cnt_last = (cnt_q == DIV_CNT_W'(DIV_ITER - 1));

	// Saturate the accumulator to the 40-bit state width.
	logic signed [STATE_W-1:0] sat_n;
	logic                      acc_fits;

	assign acc_fits = (acc_q[ACC_W-1:STATE_W-1] == '0) || (acc_q[ACC_W-1:STATE_W-1] == '1);

	always_comb begin
		if (acc_fits) begin
			sat_n = acc_q[STATE_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			sat_n = {1'b1, {(STATE_W-1){1'b0}}};
		end else begin
			sat_n = {1'b0, {(STATE_W-1){1'b1}}};
		end
	end

	// Clamp and write-back values; the ceiling test wins over the floor test.
	logic [DUTY_W-1:0]         clamped;
	logic signed [STATE_W-1:0] lm_new;
	logic [DUTY_W-1:0]         next_n;

	always_comb begin
		priority if (u_q > $signed(STATE_W'(ceil_s))) begin
			clamped = ceil_s;
		end else if (u_q < $signed(STATE_W'(floor_s))) begin
			clamped = floor_s;
		end else begin
			clamped = u_q[DUTY_W-1:0];
		end
	end

	assign lm_new = $signed(STATE_W'(clamped)) - $signed(STATE_W'(neutral_s));
	// Over current and a zero command both send the neutral duty.
	assign next_n = (over || !cmd_nz) ? neutral_s : clamped;

	// Next step.
	always_comb begin
		unique case (cw.jump)
			JMP_NEXT:     step_n = step_q + 4'd1;
			JMP_WAIT_IN:  step_n = item_fire ? step_q + 4'd1 : step_q;
			JMP_LOOP:     step_n = cnt_last ? step_q + 4'd1 : cw.target;
			JMP_WAIT_OUT: step_n = out_free ? cw.target : step_q;
			default:      step_n = STEP_WAIT;
		endcase
	end

	// Control state: step counter, configuration, loop state, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_WAIT;
			out_valid_q <= 1'b0;
			neutral_q   <= RST_NEUTRAL;
			floor_q     <= RST_FLOOR;
			ceil_q      <= RST_CEILING;
			limit_q     <= RST_LIMIT;
			pgain_q     <= RST_PGAIN;
			wgain_q     <= RST_WGAIN;
			for (int w = 0; w < WHEEL_COUNT; w++) begin
				lm_q[w]   <= '0;
				unc_q[w]  <= $signed(STATE_W'(pct_scale(RST_NEUTRAL)));
				held_q[w] <= pct_scale(RST_NEUTRAL);
			end
		end else begin
			step_q <= step_n;

			if (cfg.valid) begin
				unique case (cfg.index)
					REG_DUTY_NEUTRAL:  neutral_q <= cfg.data[PCT_W-1:0];
					REG_DUTY_FLOOR:    floor_q   <= cfg.data[PCT_W-1:0];
					REG_DUTY_CEILING:  ceil_q    <= cfg.data[PCT_W-1:0];
					REG_CURRENT_LIMIT: limit_q   <= cfg.data[LIMIT_W-1:0];
					REG_PROP_GAIN:     pgain_q   <= cfg.data[GAIN_W-1:0];
					REG_WINDUP_GAIN:   wgain_q   <= cfg.data[GAIN_W-1:0];
					default: ;
				endcase
			end

			// Write back: held duty always, loop state only when not over current.
			if (do_write) begin
				held_q[wheel_q] <= next_n;
				if (!over) begin
					lm_q[wheel_q]  <= lm_new;
					unc_q[wheel_q] <= u_q;
				end
			end

			if (do_write) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath and payload registers.
	always_ff @(posedge clk) begin
		if (item_fire) begin
			wheel_q <= item.wheel_select;
			cmd_q   <= item.target_speed;
			cur_q   <= item.motor_current;
			spd_q   <= item.measured_speed;
		end

		if (cw.mul != MUL_NONE) begin
			p_q <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
		end

		if (cw.acc == ACC_INIT) begin
			acc_q <= ACC_W'(lm_q[wheel_q]) + $signed(ACC_W'(neutral_s));
		end else if (cw.acc != ACC_NONE) begin
			acc_q <= acc_sub ? acc_q - $signed(acc_term) : acc_q + $signed(acc_term);
		end

		if (cw.win == WIN_DIFF) begin
			diff_q <= diff_n;
		end else if (cw.win == WIN_MAG) begin
			aw_neg_q <= diff_q[DIFF_W-1];
			aw_mag_q <= STATE_W'(diff_q[DIFF_W-1] ? -diff_q : diff_q);
		end

		if (cw.div == DIV_LOAD) begin
			dq_q  <= p_q[QUOT_W-1:0];
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cw.div == DIV_STEP) begin
			dq_q  <= div_quo_n;
			rem_q <= div_rem_n;
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end

		if (cw.fin == FIN_SAT) begin
			u_q <= sat_n;
		end

		if (do_write) begin
			applied_q <= held_q[wheel_q];
			next_q    <= next_n;
			over_q    <= over;
		end
	end

endmodule

`default_nettype wire

/* design/cdpsl_checker.sv */
// Port-level checker of the current-derated speed loop and its bind.
`default_nettype none

`include "current_derated_pi_speed_loop_top_macros.svh"

module cdpsl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic [cdpsl_pkg::DUTY_W-1:0] applied_duty,
	input logic [cdpsl_pkg::DUTY_W-1:0] next_duty,
	input logic                        over_current
);
	import cdpsl_pkg::*;

	// The sequencer is no longer ready for items after taking one.
	`CDPSL_CHECK_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready)

	// A stalled result stays offered with its payload unchanged.
	`CDPSL_CHECK_NEXT(a_result_holds, result_valid && !result_ready, result_valid)
	`CDPSL_CHECK_NEXT(a_result_stable, result_valid && !result_ready, $stable(applied_duty) && $stable(next_duty) && $stable(over_current))

	// Duties never leave the range the percent registers can express.
	`CDPSL_CHECK_SAME(a_duty_range, result_valid, (applied_duty <= DUTY_MAX) && (next_duty <= DUTY_MAX))

endmodule

bind current_derated_pi_speed_loop_top cdpsl_checker u_cdpsl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.applied_duty (result.applied_duty),
	.next_duty    (result.next_duty),
	.over_current (result.over_current)
);

`default_nettype wire
